// ===== rtl/tq_pkg.sv =====
package tq_pkg;

	localparam int ELEM_W       = 10;
	localparam int TEAM_W       = 10;
	localparam int NUM_ELEMENTS = 1 << ELEM_W;
	localparam int NUM_TEAMS    = 1 << TEAM_W;
	localparam int COUNT_W      = TEAM_W + 1;

	typedef logic [ELEM_W-1:0]  elem_t;
	typedef logic [TEAM_W-1:0]  team_t;
	typedef logic [COUNT_W-1:0] count_t;

	typedef enum logic [1:0] {
		CMD_ASSIGN  = 2'd0,
		CMD_ENQUEUE = 2'd1,
		CMD_DEQUEUE = 2'd2,
		CMD_CLEAR   = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ASSIGN,
		ST_ENQ_LINK,
		ST_ENQ_COMMIT,
		ST_DEQ_EMPTY,
		ST_DEQ_READ,
		ST_DEQ_POP,
		ST_DEQ_COMMIT,
		ST_CLEAR,
		ST_SWEEP
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic asn_wr;
		logic enq_link_clr;
		logic enq_commit;
		logic deq_pop;
		logic deq_commit;
		logic deq_empty;
		logic clr_commit;
		logic sweep_en;
		logic emit;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic count_zero;
		logic sweep_last;
		logic out_busy;
	} stat_t;

endpackage

// ===== rtl/grouped_fifo_team_queue.sv =====
// An assign runs ST_ASSIGN, an empty dequeue ST_DEQ_EMPTY, an enqueue ST_ENQ_LINK and
// ST_ENQ_COMMIT, a dequeue ST_DEQ_READ, ST_DEQ_POP and ST_DEQ_COMMIT; the last state holds
// while a result waits, then the result is registered. A new item is taken only in idle;
// the states follow the chain of dependent registered reads of the team, head, tail and link
// memories. Clear runs ST_CLEAR, then a 1024-entry pass zeroes the team-active memory.
// Reset is asynchronous, active low; the same pass runs after it before any item.
module grouped_fifo_team_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  logic [1:0]    cmd,
	input  tq_pkg::elem_t element,
	input  tq_pkg::team_t team_id,
	output logic          result_valid,
	input  logic          result_stall,
	output tq_pkg::elem_t out_element,
	output logic          out_valid,
	output logic          status
);
	import tq_pkg::*;

	ctl_t  ctl;
	stat_t stat;

	tq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.cmd       (cmd),
		.stat      (stat),
		.req_stall (req_stall),
		.ctl       (ctl)
	);

	tq_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.cmd          (cmd),
		.element      (element),
		.team_id      (team_id),
		.result_stall (result_stall),
		.stat         (stat),
		.result_valid (result_valid),
		.out_element  (out_element),
		.out_valid    (out_valid),
		.status       (status)
	);

`ifndef SYNTHESIS
	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.asn_wr, ctl.enq_link_clr, ctl.enq_commit, ctl.deq_pop,
			ctl.deq_commit, ctl.clr_commit, ctl.sweep_en, ctl.deq_empty}))
		else $error("more than one datapath action in a cycle");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.deq_pop |-> !stat.count_zero)
		else $error("pop from an empty team FIFO");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> !(result_valid && result_stall))
		else $error("result written over a waiting item");

	a_sweep_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.sweep_en |-> (req_stall && !ctl.accept))
		else $error("item accepted during the clearing pass");
`endif

endmodule

// ===== rtl/tq_ram.sv =====
module tq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_q <= mem_q[raddr];
	end

	assign rdata = rd_q;

endmodule

// ===== rtl/tq_ctrl.sv =====
module tq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic [1:0]    cmd,
	input  tq_pkg::stat_t stat,
	output logic          req_stall,
	output tq_pkg::ctl_t  ctl
);
	import tq_pkg::*;

	state_t state_q;
	state_t state_d;
	cmd_t   cmd_in;

	assign cmd_in = cmd_t'(cmd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					unique case (cmd_in)
						CMD_ASSIGN:  state_d = ST_ASSIGN;
						CMD_ENQUEUE: state_d = ST_ENQ_LINK;
						CMD_DEQUEUE: state_d = stat.count_zero ? ST_DEQ_EMPTY : ST_DEQ_READ;
						CMD_CLEAR:   state_d = ST_CLEAR;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_ENQ_LINK: state_d = ST_ENQ_COMMIT;
			ST_DEQ_READ: state_d = ST_DEQ_POP;
			ST_DEQ_POP:  state_d = ST_DEQ_COMMIT;
			ST_ASSIGN, ST_ENQ_COMMIT, ST_DEQ_EMPTY, ST_DEQ_COMMIT: begin
				if (!stat.out_busy) begin
					state_d = ST_IDLE;
				end
			end
			ST_CLEAR: begin
				if (!stat.out_busy) begin
					state_d = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (stat.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_SWEEP;
		endcase
	end

	always_comb begin
		ctl       = '0;
		req_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE:       ctl.accept = req_valid;
			ST_ENQ_LINK:   ctl.enq_link_clr = 1'b1;
			ST_DEQ_POP:    ctl.deq_pop = 1'b1;
			ST_SWEEP:      ctl.sweep_en = 1'b1;
			ST_ASSIGN: begin
				ctl.asn_wr = !stat.out_busy;
				ctl.emit   = !stat.out_busy;
			end
			ST_ENQ_COMMIT: begin
				ctl.enq_commit = !stat.out_busy;
				ctl.emit       = !stat.out_busy;
			end
			ST_DEQ_EMPTY: begin
				ctl.deq_empty = !stat.out_busy;
				ctl.emit      = !stat.out_busy;
			end
			ST_DEQ_COMMIT: begin
				ctl.deq_commit = !stat.out_busy;
				ctl.emit       = !stat.out_busy;
			end
			ST_CLEAR: begin
				ctl.clr_commit = !stat.out_busy;
				ctl.emit       = !stat.out_busy;
			end
			default: ctl = '0;
		endcase
	end

endmodule

// ===== rtl/tq_dp.sv =====
module tq_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  tq_pkg::ctl_t  ctl,
	input  logic [1:0]    cmd,
	input  tq_pkg::elem_t element,
	input  tq_pkg::team_t team_id,
	input  logic          result_stall,
	output tq_pkg::stat_t stat,
	output logic          result_valid,
	output tq_pkg::elem_t out_element,
	output logic          out_valid,
	output logic          status
);
	import tq_pkg::*;

	// Captured item.
	cmd_t   cmd_q;
	elem_t  elem_q;
	team_t  team_q;

	// Dequeue working registers.
	team_t  deq_team_q;
	elem_t  head_q;
	logic   last_q;

	// Team FIFO pointers and sweep counter.
	team_t  front_q;
	team_t  back_q;
	count_t count_q;
	team_t  sweep_q;

	logic   result_valid_q;
	elem_t  out_element_q;
	logic   out_valid_q;
	logic   status_q;

	// Memory ports.
	elem_t  mem_raddr;
	team_t  member_rd;
	elem_t  link_raddr;
	elem_t  link_waddr;
	elem_t  link_wdata;
	logic   link_we;
	elem_t  link_rd;
	team_t  ht_raddr;
	team_t  head_waddr;
	elem_t  head_wdata;
	logic   head_we;
	elem_t  head_rd;
	elem_t  tail_rd;
	team_t  act_waddr;
	logic   act_wdata;
	logic   act_we;
	logic   act_rd;
	logic   order_we;
	team_t  order_rd;
	logic   new_team;
	logic   deq_last;

	assign mem_raddr  = ctl.accept ? element : elem_q;
	assign ht_raddr   = (cmd_q == CMD_ENQUEUE) ? member_rd : order_rd;
	assign link_raddr = ctl.deq_pop ? head_rd : head_q;
	assign new_team   = ctl.enq_commit && !act_rd;
	assign deq_last   = (head_rd == tail_rd);
	assign order_we   = new_team && (count_q != COUNT_W'(NUM_TEAMS));

	always_comb begin
		link_we    = 1'b0;
		link_waddr = elem_q;
		link_wdata = '0;
		priority if (ctl.enq_link_clr) begin
			link_we = 1'b1;
		end else if (ctl.enq_commit && act_rd) begin
			// Append behind the current tail of the team.
			link_we    = 1'b1;
			link_waddr = tail_rd;
			link_wdata = elem_q;
		end else if (ctl.deq_commit) begin
			link_we    = 1'b1;
			link_waddr = head_q;
		end
	end

	always_comb begin
		head_we    = 1'b0;
		head_waddr = member_rd;
		head_wdata = elem_q;
		priority if (new_team) begin
			head_we = 1'b1;
		end else if (ctl.deq_commit && !last_q) begin
			head_we    = 1'b1;
			head_waddr = deq_team_q;
			head_wdata = link_rd;
		end
	end

	always_comb begin
		act_we    = 1'b0;
		act_waddr = sweep_q;
		act_wdata = 1'b0;
		priority if (ctl.sweep_en) begin
			act_we = 1'b1;
		end else if (new_team) begin
			act_we    = 1'b1;
			act_waddr = member_rd;
			act_wdata = 1'b1;
		end else if (ctl.deq_pop && deq_last) begin
			act_we    = 1'b1;
			act_waddr = order_rd;
		end
	end

	tq_ram #(.WIDTH(TEAM_W), .DEPTH(NUM_ELEMENTS)) u_member (
		.clk   (clk),
		.we    (ctl.asn_wr),
		.waddr (elem_q),
		.wdata (team_q),
		.raddr (mem_raddr),
		.rdata (member_rd)
	);

	tq_ram #(.WIDTH(ELEM_W), .DEPTH(NUM_ELEMENTS)) u_link (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (link_raddr),
		.rdata (link_rd)
	);

	tq_ram #(.WIDTH(ELEM_W), .DEPTH(NUM_TEAMS)) u_head (
		.clk   (clk),
		.we    (head_we),
		.waddr (head_waddr),
		.wdata (head_wdata),
		.raddr (ht_raddr),
		.rdata (head_rd)
	);

	tq_ram #(.WIDTH(ELEM_W), .DEPTH(NUM_TEAMS)) u_tail (
		.clk   (clk),
		.we    (ctl.enq_commit),
		.waddr (member_rd),
		.wdata (elem_q),
		.raddr (ht_raddr),
		.rdata (tail_rd)
	);

	tq_ram #(.WIDTH(1), .DEPTH(NUM_TEAMS)) u_active (
		.clk   (clk),
		.we    (act_we),
		.waddr (act_waddr),
		.wdata (act_wdata),
		.raddr (member_rd),
		.rdata (act_rd)
	);

	tq_ram #(.WIDTH(TEAM_W), .DEPTH(NUM_TEAMS)) u_order (
		.clk   (clk),
		.we    (order_we),
		.waddr (back_q),
		.wdata (member_rd),
		.raddr (front_q),
		.rdata (order_rd)
	);

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q  <= cmd_t'(cmd);
			elem_q <= element;
			team_q <= team_id;
		end
		if (ctl.deq_pop) begin
			deq_team_q <= order_rd;
			head_q     <= head_rd;
			last_q     <= deq_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
			sweep_q <= '0;
		end else begin
			if (ctl.sweep_en) begin
				sweep_q <= sweep_q + TEAM_W'(1);
			end
			priority if (ctl.clr_commit) begin
				front_q <= '0;
				back_q  <= '0;
				count_q <= '0;
			end else if (order_we) begin
				back_q  <= back_q + TEAM_W'(1);
				count_q <= count_q + COUNT_W'(1);
			end else if (ctl.deq_pop && deq_last) begin
				front_q <= front_q + TEAM_W'(1);
				count_q <= count_q - COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			out_element_q <= ctl.deq_commit ? head_q : '0;
			out_valid_q   <= ctl.deq_commit;
			status_q      <= ctl.deq_empty;
		end
	end

	assign stat.count_zero = (count_q == '0);
	assign stat.sweep_last = (sweep_q == TEAM_W'(NUM_TEAMS - 1));
	assign stat.out_busy   = result_valid_q && result_stall;

	assign result_valid = result_valid_q;
	assign out_element  = out_element_q;
	assign out_valid    = out_valid_q;
	assign status       = status_q;

endmodule
